@@ rtl/ura_pkg.sv @@
// Package for the ultrasonic ranger: command and key codes, reset values and limits.
`default_nettype none
package ura_pkg;

  // Command codes
  localparam logic [2:0] CMD_TICK_10US = 3'd0;
  localparam logic [2:0] CMD_TICK_1MS  = 3'd1;
  localparam logic [2:0] CMD_ECHO      = 3'd2;
  localparam logic [2:0] CMD_KEY       = 3'd3;
  localparam logic [2:0] CMD_REFRESH   = 3'd4;

  // Key codes
  localparam logic [2:0] KEY_UP_1     = 3'd0;
  localparam logic [2:0] KEY_UP_10    = 3'd1;
  localparam logic [2:0] KEY_UP_100   = 3'd2;
  localparam logic [2:0] KEY_DOWN_1   = 3'd3;
  localparam logic [2:0] KEY_DOWN_10  = 3'd4;
  localparam logic [2:0] KEY_DOWN_100 = 3'd5;

  // Register indexes
  localparam logic REG_REARM   = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam int unsigned ECHO_COUNT_MAX_DEF = 4095;

  localparam logic [6:0]  MS_MAX          = 7'd127;
  localparam logic [6:0]  REARM_RST       = 7'd60;
  localparam logic [6:0]  TIMEOUT_RST     = 7'd120;
  localparam logic [6:0]  MS_COUNT_RST    = 7'd60;
  localparam logic [11:0] THRESH_RST      = 12'd200;
  localparam logic [11:0] THRESH_TOP      = 12'd4000;
  localparam logic [11:0] THRESH_TOP_10   = 12'd3990;
  localparam logic [11:0] THRESH_TOP_100  = 12'd3900;
  localparam logic [11:0] STEP_1          = 12'd1;
  localparam logic [11:0] STEP_10         = 12'd10;
  localparam logic [11:0] STEP_100        = 12'd100;

  localparam logic [15:0] TIME_SAT = 16'd65535;
  localparam logic [12:0] DIST_SAT = 13'd8191;

  // floor(x/10) == (x * DIV10_MUL) >> DIV10_SHIFT for x below 2^22
  localparam int unsigned DIV10_SHIFT = 24;
  localparam logic [20:0] DIV10_MUL   = 21'd1677722;

endpackage
`default_nettype wire

@@ rtl/ultrasonic_ranger_with_alarm_top.sv @@
// Ultrasonic echo-time ranging controller with distance alarm, top level.
`default_nettype none
// Usage
//   Requests arrive on the input channel (in_valid / in_stall) carrying command,
//   echo_level and key_code. Commands: 10 us tick, 1 ms tick, echo level sample,
//   key press on the alarm threshold, alarm refresh. Every request yields exactly
//   one result on the output channel (out_valid / out_stall): trigger pulse flag,
//   measurement-done flag, echo time in us, distance in mm, LED level, current
//   threshold and the waiting-for-echo flag.
//   A request is held in the input register, then all the work is done in one
//   pass into the result register, where the controller state is updated as well.
//   Throughput is one request per cycle, set by that single pass, while the result is not stalled.
//   A stalled result holds in the result register; the input register still takes
//   one more request, and in_stall rises only when both stages are full.
//   rst (synchronous) empties both stages and loads the reset state: delay 60 ms,
//   timeout 120 ms, ms counter 60, trigger armed, threshold 200 mm, LED on.
//   The two 7-bit registers (rearm delay at 0x0, echo timeout at 0x4) are written
//   over the APB-style port; only write them while no request is in flight.
//   Distance is 17*ticks/10 by reciprocal multiplication, saturated to 13 bits.
module ultrasonic_ranger_with_alarm_top #(
  parameter int unsigned ECHO_COUNT_MAX = ura_pkg::ECHO_COUNT_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB-style register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic        echo_level,
  input  wire logic [2:0]  key_code,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             trigger_pulse,
  output logic             measure_done,
  output logic [15:0]      echo_time_us,
  output logic [12:0]      distance_mm,
  output logic             alarm_led,
  output logic [11:0]      alarm_threshold_mm,
  output logic             waiting_echo
);

  localparam int unsigned TW = $clog2(ECHO_COUNT_MAX + 1);  // tick counter width
  localparam int unsigned PW = TW + 5;                      // 17*ticks width
  localparam int unsigned MW = PW + 21;                     // reciprocal product width
  localparam int unsigned QW = MW - ura_pkg::DIV10_SHIFT;   // quotient width
  localparam int unsigned EW = TW + 4;                      // 10*ticks width
  localparam logic [TW-1:0] TICK_MAX = TW'(ECHO_COUNT_MAX);

  // ---------------- configuration registers ----------------
  logic [6:0] rearm_delay_ms;
  logic [6:0] echo_timeout_ms;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rearm_delay_ms  <= ura_pkg::REARM_RST;
      echo_timeout_ms <= ura_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == ura_pkg::REG_REARM) rearm_delay_ms  <= pwdata[6:0];
      else                                echo_timeout_ms <= pwdata[6:0];
    end
  end

  always_comb begin
    if (paddr[2] == ura_pkg::REG_REARM) prdata = {25'd0, rearm_delay_ms};
    else                                prdata = {25'd0, echo_timeout_ms};
  end

  // ---------------- flow control ----------------
  logic       s1_valid;
  logic [2:0] s1_command;
  logic       s1_level;
  logic [2:0] s1_key;
  logic       take;   // request enters input register
  logic       adv;    // result register can load
  logic       load;   // input register moves to result register

  assign adv      = !out_valid || !out_stall;
  assign load     = s1_valid && adv;
  assign in_stall = s1_valid && !adv;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_command <= command;
      s1_level   <= echo_level;
      s1_key     <= key_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // ---------------- controller state ----------------
  logic [TW-1:0] echo_ticks, echo_ticks_next;
  logic [6:0]    ms_count, ms_count_next;
  logic          armed, armed_next;
  logic          in_pulse, in_pulse_next;
  logic [TW-1:0] last_echo_ticks, last_echo_ticks_next;
  logic [12:0]   distance_reg, distance_reg_next;
  logic [11:0]   threshold_reg, threshold_reg_next;
  logic          led_reg, led_reg_next;
  logic          trig, done;

  // distance = floor(17*ticks/10), via reciprocal multiply
  logic [PW-1:0] times17;
  logic [MW-1:0] recip_prod;
  logic [QW-1:0] quot;
  logic [12:0]   dist_sat;
  // echo time = 10*ticks
  logic [EW-1:0] times10;
  logic [15:0]   etime_sat;

  assign times17    = (PW'(echo_ticks) << 4) + PW'(echo_ticks);
  assign recip_prod = MW'(times17) * MW'(ura_pkg::DIV10_MUL);
  assign quot       = recip_prod[MW-1:ura_pkg::DIV10_SHIFT];
  assign dist_sat   = (32'(quot) > 32'(ura_pkg::DIST_SAT)) ? ura_pkg::DIST_SAT : 13'(quot);

  always_comb begin
    echo_ticks_next      = echo_ticks;
    ms_count_next        = ms_count;
    armed_next           = armed;
    in_pulse_next        = in_pulse;
    last_echo_ticks_next = last_echo_ticks;
    distance_reg_next    = distance_reg;
    threshold_reg_next   = threshold_reg;
    led_reg_next         = led_reg;
    trig                 = 1'b0;
    done                 = 1'b0;

    // tick counters, both saturating
    if (s1_command == ura_pkg::CMD_TICK_10US) begin
      if (echo_ticks < TICK_MAX) echo_ticks_next = echo_ticks + TW'(1);
    end else if (s1_command == ura_pkg::CMD_TICK_1MS) begin
      if (ms_count < ura_pkg::MS_MAX) ms_count_next = ms_count + 7'd1;
    end

    // trigger check runs on every request
    if ((armed && ms_count_next >= rearm_delay_ms) ||
        (!armed && ms_count_next >= echo_timeout_ms)) begin
      ms_count_next = 7'd0;
      armed_next    = 1'b0;
      trig          = 1'b1;
    end

    case (s1_command)
      ura_pkg::CMD_ECHO: begin
        if (s1_level && !in_pulse) begin
          echo_ticks_next = '0;
          in_pulse_next   = 1'b1;
        end else if (!s1_level && in_pulse) begin
          // echo_ticks is untouched by an echo request, so the current value is used
          last_echo_ticks_next = echo_ticks;
          distance_reg_next    = dist_sat;
          in_pulse_next        = 1'b0;
          armed_next           = 1'b1;
          ms_count_next        = 7'd0;
          done                 = 1'b1;
        end
      end
      ura_pkg::CMD_KEY: begin
        case (s1_key)
          ura_pkg::KEY_UP_1:
            if (threshold_reg < ura_pkg::THRESH_TOP)
              threshold_reg_next = threshold_reg + ura_pkg::STEP_1;
          ura_pkg::KEY_UP_10:
            if (threshold_reg < ura_pkg::THRESH_TOP_10)
              threshold_reg_next = threshold_reg + ura_pkg::STEP_10;
          ura_pkg::KEY_UP_100:
            if (threshold_reg < ura_pkg::THRESH_TOP_100)
              threshold_reg_next = threshold_reg + ura_pkg::STEP_100;
          ura_pkg::KEY_DOWN_1:
            if (threshold_reg >= ura_pkg::STEP_1)
              threshold_reg_next = threshold_reg - ura_pkg::STEP_1;
          ura_pkg::KEY_DOWN_10:
            if (threshold_reg >= ura_pkg::STEP_10)
              threshold_reg_next = threshold_reg - ura_pkg::STEP_10;
          ura_pkg::KEY_DOWN_100:
            if (threshold_reg >= ura_pkg::STEP_100)
              threshold_reg_next = threshold_reg - ura_pkg::STEP_100;
          default: ;
        endcase
      end
      ura_pkg::CMD_REFRESH: begin
        // LED blinks while the target is inside the threshold, steady on otherwise
        if (32'(distance_reg) < 32'(threshold_reg)) led_reg_next = !led_reg;
        else                                        led_reg_next = 1'b1;
      end
      default: ;
    endcase
  end

  assign times10   = (EW'(last_echo_ticks_next) << 3) + (EW'(last_echo_ticks_next) << 1);
  assign etime_sat = (32'(times10) > 32'(ura_pkg::TIME_SAT)) ? ura_pkg::TIME_SAT
                                                               : 16'(times10);

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_ticks      <= '0;
      ms_count        <= ura_pkg::MS_COUNT_RST;
      armed           <= 1'b1;
      in_pulse        <= 1'b0;
      last_echo_ticks <= '0;
      distance_reg    <= '0;
      threshold_reg   <= ura_pkg::THRESH_RST;
      led_reg         <= 1'b1;
    end else if (load) begin
      echo_ticks      <= echo_ticks_next;
      ms_count        <= ms_count_next;
      armed           <= armed_next;
      in_pulse        <= in_pulse_next;
      last_echo_ticks <= last_echo_ticks_next;
      distance_reg    <= distance_reg_next;
      threshold_reg   <= threshold_reg_next;
      led_reg         <= led_reg_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (load) begin
      trigger_pulse      <= trig;
      measure_done       <= done;
      echo_time_us       <= etime_sat;
      distance_mm        <= distance_reg_next;
      alarm_led          <= led_reg_next;
      alarm_threshold_mm <= threshold_reg_next;
      waiting_echo       <= !armed_next;
    end
  end

endmodule
`default_nettype wire
